/* src/lfd_pkg.sv */
// ----------------------------------------------------------------------------
// lfd_pkg
// Shared types and constants for the length-prefixed frame decoder.
// ----------------------------------------------------------------------------
package lfd_pkg;

    localparam int HdrBytes = 8;
    localparam int HdrCntW  = $clog2(HdrBytes);
    localparam int LenW     = 32;
    localparam int WordW    = 16;
    localparam int ByteW    = 8;
    localparam int HdrW     = HdrBytes * ByteW;

    localparam int QDepth   = 4;
    localparam int QAw      = $clog2(QDepth);
    localparam int QCntW    = $clog2(QDepth + 1);

    localparam int OutDataW = ByteW + LenW + 2 * WordW;

    typedef struct packed {
        logic [WordW-1:0] frame_type;
        logic [WordW-1:0] frame_flags;
        logic [LenW-1:0]  frame_length;
        logic             frame_end;
        logic             byte_valid;
        logic [ByteW-1:0] payload_byte;
    } t_result;

    typedef struct packed {
        logic    push;
        t_result item;
    } t_push;

endpackage

/* src/lfd_front.sv */
// ----------------------------------------------------------------------------
// lfd_front
// Accepts stream bytes, collects the header and classifies each byte.
// ----------------------------------------------------------------------------
module lfd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [lfd_pkg::ByteW-1:0] i_byte,
    input  logic                      i_q_ready,
    output lfd_pkg::t_push            o_push
);

    logic                         r_in_payload;
    logic [lfd_pkg::HdrCntW-1:0]  r_count;
    logic [lfd_pkg::HdrW-1:0]     r_shift;
    logic [lfd_pkg::LenW-1:0]     r_left;

    logic [lfd_pkg::HdrW-1:0]     n_shift;
    logic [lfd_pkg::LenW-1:0]     n_len;
    logic                         accept;
    logic                         hdr_last;
    logic                         pay_last;

    assign o_ready  = i_q_ready;
    assign accept   = i_valid && i_q_ready;
    assign n_shift  = {r_shift[lfd_pkg::HdrW-lfd_pkg::ByteW-1:0], i_byte};
    assign n_len    = n_shift[lfd_pkg::HdrW-1 -: lfd_pkg::LenW];
    assign hdr_last = (r_count == lfd_pkg::HdrCntW'(lfd_pkg::HdrBytes - 1));
    assign pay_last = (r_left <= lfd_pkg::LenW'(1));

    always_comb begin
        o_push = '0;
        if (r_in_payload) begin
            o_push.push              = accept;
            o_push.item.payload_byte = i_byte;
            o_push.item.byte_valid   = 1'b1;
            o_push.item.frame_end    = pay_last;
            o_push.item.frame_length = r_shift[lfd_pkg::HdrW-1 -: lfd_pkg::LenW];
            o_push.item.frame_flags  = r_shift[2*lfd_pkg::WordW-1 -: lfd_pkg::WordW];
            o_push.item.frame_type   = r_shift[lfd_pkg::WordW-1:0];
        end else begin
            o_push.push              = accept && hdr_last && (n_len == '0);
            o_push.item.payload_byte = '0;
            o_push.item.byte_valid   = 1'b0;
            o_push.item.frame_end    = 1'b1;
            o_push.item.frame_length = n_len;
            o_push.item.frame_flags  = n_shift[2*lfd_pkg::WordW-1 -: lfd_pkg::WordW];
            o_push.item.frame_type   = n_shift[lfd_pkg::WordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_count      <= '0;
            r_left       <= '0;
        end else if (accept) begin
            if (r_in_payload) begin
                if (pay_last) begin
                    r_left       <= '0;
                    r_in_payload <= 1'b0;
                end else begin
                    r_left <= r_left - lfd_pkg::LenW'(1);
                end
            end else if (!hdr_last) begin
                r_count <= r_count + lfd_pkg::HdrCntW'(1);
            end else begin
                r_count <= '0;
                if (n_len != '0) begin
                    r_left       <= n_len;
                    r_in_payload <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !r_in_payload) begin
            r_shift <= n_shift;
        end
    end

    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_left != '0))
        else $error("payload state with no bytes left");

    a_payload_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_count == '0))
        else $error("header count moved during payload");

endmodule

/* src/lfd_queue.sv */
// ----------------------------------------------------------------------------
// lfd_queue
// Short result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module lfd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lfd_pkg::t_push      i_push,
    output logic                o_ready,
    output logic                o_valid,
    output lfd_pkg::t_result    o_item,
    input  logic                i_pop
);

    lfd_pkg::t_result             r_mem [lfd_pkg::QDepth];
    logic [lfd_pkg::QAw-1:0]      r_wr;
    logic [lfd_pkg::QAw-1:0]      r_rd;
    logic [lfd_pkg::QCntW-1:0]    r_cnt;

    logic push;
    logic pop;

    assign o_ready = (r_cnt != lfd_pkg::QCntW'(lfd_pkg::QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_push.push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push.item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + lfd_pkg::QAw'(1);
            end
            if (pop) begin
                r_rd <= r_rd + lfd_pkg::QAw'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + lfd_pkg::QCntW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - lfd_pkg::QCntW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> o_ready)
        else $error("push into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= lfd_pkg::QCntW'(lfd_pkg::QDepth))
        else $error("queue count out of range");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("empty queue with pointers apart");

endmodule

/* src/lfd_back.sv */
// ----------------------------------------------------------------------------
// lfd_back
// Output register stage driving the result stream.
// ----------------------------------------------------------------------------
module lfd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  lfd_pkg::t_result              i_item,
    output logic                          o_pop,
    output logic                          o_tvalid,
    input  logic                          i_tready,
    output logic [lfd_pkg::OutDataW-1:0]  o_tdata,
    output logic                          o_tuser,
    output logic                          o_tlast
);

    logic             r_valid;
    lfd_pkg::t_result r_item;

    assign o_pop    = i_valid && (!r_valid || i_tready);
    assign o_tvalid = r_valid;
    assign o_tdata  = {r_item.frame_type, r_item.frame_flags, r_item.frame_length,
                       r_item.payload_byte};
    assign o_tuser  = r_item.byte_valid;
    assign o_tlast  = r_item.frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

/* src/length_prefixed_frame_decoder_top.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_decoder_top
// Deframer for a byte stream of length-prefixed frames.
// ----------------------------------------------------------------------------
// Input: one byte per transfer on the slave stream. Each frame starts with an
// 8-byte big-endian header (32-bit length, 16-bit flags, 16-bit type),
// followed by that many payload bytes.
// Output: one transfer per payload byte, carrying the header fields; tlast
// marks the last byte of a frame. A zero-length frame gives one transfer with
// tuser low (no valid byte) on its last header byte. Other header bytes give
// no transfer.
// Throughput: one byte per cycle while the queue has room, set by the
// header/count update in the front stage. Each result is written to the queue
// when its byte is accepted, then to the output register.
// A stalled receiver fills the 4-entry queue; tready on the input drops only
// when the queue is full. Reset clears the header state, queue and output.
// ----------------------------------------------------------------------------
module length_prefixed_frame_decoder_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] data_byte
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lfd_pkg::OutDataW-1:0]  o_m_tdata,   // [7:0] payload_byte,
                                                       // [39:8] frame_length,
                                                       // [55:40] frame_flags,
                                                       // [71:56] frame_type
    output logic                          o_m_tuser,   // [0] byte_valid
    output logic                          o_m_tlast    // frame_end
);

    lfd_pkg::t_push   push;
    lfd_pkg::t_result q_item;
    logic             q_ready;
    logic             q_valid;
    logic             pop;

    lfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_byte    (i_s_tdata),
        .i_q_ready (q_ready),
        .o_push    (push)
    );

    lfd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (pop)
    );

    lfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (q_valid),
        .i_item   (q_item),
        .o_pop    (pop),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the length-prefixed frame decoder. Bytes of framed
// streams go in on the slave stream; an in-bench deframer predicts each
// payload transfer (and the single marker transfer of an empty frame) and
// every transfer seen on the master stream is compared with it in order.
// Both stream sides idle at random, with free-running stretches in between.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int CycleLimit = 400000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata;   // [7:0] data_byte
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [lfd_pkg::OutDataW-1:0]  o_m_tdata;   // [7:0] payload_byte, [39:8] frame_length,
                                                // [55:40] frame_flags, [71:56] frame_type
    logic                          o_m_tuser;   // [0] byte_valid
    logic                          o_m_tlast;   // frame_end

    // deframer prediction state
    logic                          hdr_busy_n;  // 0: collecting header, 1: in payload
    logic [lfd_pkg::HdrCntW-1:0]   hdr_cnt;
    logic [lfd_pkg::HdrW-1:0]      hdr_bits;
    logic [lfd_pkg::LenW-1:0]      pay_left;

    lfd_pkg::t_result              exp_results[$];
    int                            n_errors;
    int                            n_sent;
    int                            cycle_cnt;
    bit                            tx_free_run;
    bit                            rx_free_run;

    length_prefixed_frame_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(0, 2);
        end else if (r < 95) begin
            return $urandom_range(3, 8);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        lfd_pkg::t_result res;
        res = '0;
        if (hdr_busy_n) begin
            res.payload_byte = b;
            res.byte_valid   = 1'b1;
            res.frame_end    = (pay_left <= 1);
            res.frame_length = hdr_bits[63:32];
            res.frame_flags  = hdr_bits[31:16];
            res.frame_type   = hdr_bits[15:0];
            exp_results.insert(exp_results.size(), res);
            if (pay_left <= 1) begin
                pay_left   = '0;
                hdr_busy_n = 1'b0;
            end else begin
                pay_left = pay_left - lfd_pkg::LenW'(1);
            end
        end else begin
            hdr_bits = {hdr_bits[lfd_pkg::HdrW-9:0], b};
            if (hdr_cnt != lfd_pkg::HdrCntW'(lfd_pkg::HdrBytes - 1)) begin
                hdr_cnt = hdr_cnt + lfd_pkg::HdrCntW'(1);
            end else begin
                hdr_cnt = '0;
                if (hdr_bits[63:32] == '0) begin
                    res.frame_end    = 1'b1;
                    res.frame_flags  = hdr_bits[31:16];
                    res.frame_type   = hdr_bits[15:0];
                    exp_results.insert(exp_results.size(), res);
                end else begin
                    pay_left   = hdr_bits[63:32];
                    hdr_busy_n = 1'b1;
                end
            end
        end
    endtask

    // call at a falling edge; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        deframe_byte(b);
        n_sent++;
        gap = tx_free_run ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= 8'($urandom);
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic send_header(input logic [31:0] len, input logic [15:0] flags,
                               input logic [15:0] kind);
        logic [63:0] hdr;
        hdr = {len, flags, kind};
        for (int i = 7; i >= 0; i--) begin
            send_byte(hdr[i*8 +: 8]);
        end
    endtask

    task automatic send_random_frame();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            len = 0;
        end else if (r < 80) begin
            len = $urandom_range(1, 8);
        end else if (r < 95) begin
            len = $urandom_range(9, 32);
        end else begin
            len = $urandom_range(33, 200);
        end
        send_header(32'(len), 16'($urandom), 16'($urandom));
        for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom));
        end
    endtask

    // hold off the sender until every expected transfer has come out
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic test_directed();
        send_header(32'h0000_0000, 16'hFFFF, 16'h0000);
        send_header(32'h0000_0002, 16'h0000, 16'hFFFF);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_header(32'h0000_0001, 16'hA5A5, 16'h5A5A);
        send_byte(8'h80);
    endtask

    task automatic test_back_to_back();
        tx_free_run = 1'b1;
        rx_free_run = 1'b1;
        while (n_sent < 250) send_random_frame();
        tx_free_run = 1'b0;
        rx_free_run = 1'b0;
    endtask

    task automatic test_random_frames();
        while (n_sent < 600) send_random_frame();
        wait_drained();
        while (n_sent < 1000) send_random_frame();
    endtask

    // a frame of the largest length never ends within the run
    task automatic test_max_length();
        send_header(32'hFFFF_FFFF, 16'($urandom), 16'($urandom));
        repeat (40) send_byte(8'($urandom));
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        n_errors    = 0;
        n_sent      = 0;
        tx_free_run = 1'b0;
        rx_free_run = 1'b0;
        hdr_busy_n  = 1'b0;
        hdr_cnt     = '0;
        hdr_bits    = '0;
        pay_left    = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_back_to_back();
        test_random_frames();
        test_max_length();

        i_s_tvalid <= 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("** length_prefixed_frame_decoder_top: PASSED **");
        end else begin
            $display("** length_prefixed_frame_decoder_top: FAILED **");
        end
        $finish;
    end

    initial begin
        i_m_tready = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            if (!rx_free_run) begin
                i_m_tready <= 1'b0;
                repeat (idle_len() + 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        lfd_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (exp_results.size() == 0) begin
                $error("unexpected transfer: tdata %h tuser %b tlast %b",
                       o_m_tdata, o_m_tuser, o_m_tlast);
                n_errors++;
            end else begin
                want = exp_results.pop_front();
                if (o_m_tdata[7:0] !== want.payload_byte) begin
                    $error("payload_byte: expected %h, got %h",
                           want.payload_byte, o_m_tdata[7:0]);
                    n_errors++;
                end
                if (o_m_tuser !== want.byte_valid) begin
                    $error("byte_valid: expected %b, got %b", want.byte_valid, o_m_tuser);
                    n_errors++;
                end
                if (o_m_tlast !== want.frame_end) begin
                    $error("frame_end: expected %b, got %b", want.frame_end, o_m_tlast);
                    n_errors++;
                end
                if (o_m_tdata[39:8] !== want.frame_length) begin
                    $error("frame_length: expected %h, got %h",
                           want.frame_length, o_m_tdata[39:8]);
                    n_errors++;
                end
                if (o_m_tdata[55:40] !== want.frame_flags) begin
                    $error("frame_flags: expected %h, got %h",
                           want.frame_flags, o_m_tdata[55:40]);
                    n_errors++;
                end
                if (o_m_tdata[71:56] !== want.frame_type) begin
                    $error("frame_type: expected %h, got %h",
                           want.frame_type, o_m_tdata[71:56]);
                    n_errors++;
                end
            end
        end
    end

    initial cycle_cnt = 0;
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt == CycleLimit) begin
            $display("** length_prefixed_frame_decoder_top: FAILED **");
            $finish;
        end
    end

endmodule
